>>> rtl/rem_pkg.sv
// ----------------------------------------------------------------------------
// Rotary encoder settings menu package
// Shared types, codes and limits for the settings menu and its step logic.
// ----------------------------------------------------------------------------
`default_nettype none

package rem_pkg;

  typedef enum logic [2:0] {
    MODE_VIEW       = 3'd0,
    MODE_MENU       = 3'd1,
    MODE_EDIT_PH    = 3'd2,
    MODE_EDIT_NUT   = 3'd3,
    MODE_EDIT_WATER = 3'd4
  } mode_t;

  localparam logic [1:0] KIND_ENC    = 2'd0;
  localparam logic [1:0] KIND_BTN    = 2'd1;
  localparam logic [1:0] KIND_WATER  = 2'd2;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  localparam logic [1:0] REG_MENU_COUNT       = 2'd0;
  localparam logic [1:0] REG_DETENT_THRESHOLD = 2'd1;
  localparam logic [1:0] REG_LEVEL_THRESHOLD  = 2'd2;

  localparam logic [2:0] MENU_COUNT_RESET       = 3'd4;
  localparam logic [5:0] DETENT_THRESHOLD_RESET = 6'd10;
  localparam logic [9:0] LEVEL_THRESHOLD_RESET  = 10'd100;

  localparam logic [2:0] MENU_COUNT_MAX = 3'd4;
  localparam logic [5:0] DETENT_MAX     = 6'd62;

  localparam logic [6:0] PH_MIN      = 7'd30;
  localparam logic [6:0] PH_MAX      = 7'd100;
  localparam logic [6:0] PH_RESET    = 7'd65;
  localparam logic [4:0] NUT_MAX     = 5'd20;
  localparam logic [4:0] NUT_RESET   = 5'd2;
  localparam logic [1:0] WATER_MIN   = 2'd1;
  localparam logic [1:0] WATER_MAX   = 2'd3;
  localparam logic [1:0] WATER_RESET = 2'd3;

  typedef struct packed {
    logic [2:0] menu_count;
    logic [5:0] detent_threshold;
    logic [9:0] level_threshold;
  } rem_cfg_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       pin_a;
    logic       pin_b;
    logic [9:0] level_low;
    logic [9:0] level_mid;
    logic [9:0] level_high;
  } rem_item_t;

  typedef struct packed {
    mode_t             mode;
    logic              prev_a;
    logic              prev_b;
    logic signed [6:0] detent;
    logic [1:0]        menu_pos;
    logic [6:0]        ph;
    logic [4:0]        nutrient;
    logic [1:0]        water_goal;
    logic [1:0]        water_level;
    logic              pump;
  } rem_state_t;

endpackage

`default_nettype wire

>>> rtl/rem_step.sv
// ----------------------------------------------------------------------------
// Settings menu step logic
// Next state of the menu, the settings and the pump for one input item.
// ----------------------------------------------------------------------------
`default_nettype none

module rem_step import rem_pkg::*; (
  input  wire rem_state_t state,
  input  wire rem_item_t  item,
  input  wire rem_cfg_t   cfg,
  output rem_state_t      state_next
);

  logic              a_chg;
  logic              b_chg;
  logic              step;
  logic              cw;
  logic [2:0]        cnt;
  logic [5:0]        th;
  logic signed [6:0] th_pos;
  logic signed [6:0] th_neg;
  logic signed [6:0] det_inc;
  logic signed [6:0] det_dec;
  logic [2:0]        pos_inc;
  logic [1:0]        water_cnt;

  always_comb begin
    a_chg = item.pin_a != state.prev_a;
    b_chg = item.pin_b != state.prev_b;
    step  = (item.kind == KIND_ENC) && (a_chg || b_chg);
    cw    = a_chg ? (item.pin_a != item.pin_b) : (item.pin_a == item.pin_b);

    if (cfg.menu_count == 3'd0) begin
      cnt = 3'd1;
    end else if (cfg.menu_count > MENU_COUNT_MAX) begin
      cnt = MENU_COUNT_MAX;
    end else begin
      cnt = cfg.menu_count;
    end
    th     = (cfg.detent_threshold > DETENT_MAX) ? DETENT_MAX : cfg.detent_threshold;
    th_pos = signed'({1'b0, th});
    th_neg = -th_pos;

    det_inc   = state.detent + 7'sd1;
    det_dec   = state.detent - 7'sd1;
    pos_inc   = {1'b0, state.menu_pos} + ((det_inc > th_pos) ? 3'd1 : 3'd0);
    water_cnt = {1'b0, item.level_low  > cfg.level_threshold}
              + {1'b0, item.level_mid  > cfg.level_threshold}
              + {1'b0, item.level_high > cfg.level_threshold};

    state_next = state;

    if (item.kind == KIND_ENC) begin
      state_next.prev_a = item.pin_a;
      state_next.prev_b = item.pin_b;
    end

    if (step) begin
      unique case (state.mode)
        MODE_MENU: begin
          if (cw) begin
            state_next.detent   = (det_inc > th_pos) ? 7'sd0 : det_inc;
            state_next.menu_pos = (pos_inc >= cnt) ? 2'd0 : pos_inc[1:0];
          end else if (det_dec < th_neg) begin
            state_next.detent   = 7'sd0;
            state_next.menu_pos = (state.menu_pos == 2'd0) ? 2'(cnt - 3'd1)
                                                           : state.menu_pos - 2'd1;
          end else begin
            state_next.detent = det_dec;
          end
        end
        MODE_EDIT_PH: begin
          if (cw) begin
            state_next.ph = (state.ph >= PH_MAX) ? PH_MAX : state.ph + 7'd1;
          end else begin
            state_next.ph = (state.ph <= PH_MIN) ? PH_MIN : state.ph - 7'd1;
          end
        end
        MODE_EDIT_NUT: begin
          if (cw) begin
            state_next.nutrient = (state.nutrient >= NUT_MAX) ? NUT_MAX
                                                              : state.nutrient + 5'd1;
          end else begin
            state_next.nutrient = (state.nutrient == 5'd0) ? 5'd0 : state.nutrient - 5'd1;
          end
        end
        MODE_EDIT_WATER: begin
          if (cw) begin
            state_next.water_goal = (state.water_goal >= WATER_MAX) ? WATER_MAX
                                                                    : state.water_goal + 2'd1;
          end else begin
            state_next.water_goal = (state.water_goal <= WATER_MIN) ? WATER_MIN
                                                                    : state.water_goal - 2'd1;
          end
        end
        default: begin
        end
      endcase
    end

    if (item.kind == KIND_BTN) begin
      unique case (state.mode)
        MODE_VIEW: begin
          state_next.mode = MODE_MENU;
        end
        MODE_MENU: begin
          unique case (state.menu_pos)
            2'd0:    state_next.mode = MODE_EDIT_PH;
            2'd1:    state_next.mode = MODE_EDIT_NUT;
            2'd2:    state_next.mode = MODE_EDIT_WATER;
            default: state_next.mode = MODE_VIEW;
          endcase
        end
        MODE_EDIT_PH, MODE_EDIT_NUT, MODE_EDIT_WATER: begin
          state_next.mode = MODE_MENU;
          state_next.pump = state.water_level < state.water_goal;
        end
        default: begin
        end
      endcase
    end

    if (item.kind == KIND_WATER) begin
      state_next.water_level = water_cnt;
      state_next.pump        = water_cnt < state.water_goal;
    end
  end

endmodule

`default_nettype wire

>>> rtl/rotary_encoder_settings_menu.sv
// ----------------------------------------------------------------------------
// Rotary encoder settings menu
// Decodes encoder steps and button presses into a mode menu with clamped
// settings, and counts wet water sensors to drive the pump.
// ----------------------------------------------------------------------------
//   Channel  Direction  Handshake               Payload
//   s_axis   in         s_axis_tvalid/tready    tuser kind, tdata pins and levels
//   m_axis   out        m_axis_tvalid/tready    tdata mode, settings, water, pump
//   cfg      in         cfg_valid/cfg_ready     cfg_index, cfg_data
//
// Every input transfer gives one output transfer: the item is held in the
// input register, then goes through the step logic into the output register.
// One item per cycle is sustained while the output does not stall; the step
// logic and the state registers are the only path between the two registers.
// A stalled output holds the output register, then the input register, then
// drops s_axis_tready. Reset sets the state, valid flags and config to defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module rotary_encoder_settings_menu import rem_pkg::*; (
  input  wire        clk,
  input  wire        rst,
  input  wire        s_axis_tvalid,
  output logic       s_axis_tready,
  input  wire [31:0] s_axis_tdata,  // pin_a, pin_b, level_low, level_mid, level_high
  input  wire [1:0]  s_axis_tuser,  // kind
  output logic       m_axis_tvalid,
  input  wire        m_axis_tready,
  output logic [23:0] m_axis_tdata, // mode, selected_entry, ph_target_tenths,
                                    // nutrient_setting, water_target, water_now,
                                    // pump_on, zero fill
  input  wire        cfg_valid,
  output logic       cfg_ready,
  input  wire [1:0]  cfg_index,
  input  wire [9:0]  cfg_data
);

  rem_cfg_t   cfg;
  rem_item_t  in_item;
  logic       in_vld;
  rem_state_t state;
  rem_state_t state_next;
  logic       advance;
  logic       fire;
  logic       load_in;

  assign cfg_ready     = 1'b1;
  assign advance       = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = !in_vld || advance;
  assign load_in       = s_axis_tvalid && s_axis_tready;
  assign fire          = in_vld && advance;

  rem_step u_step (
    .state      (state),
    .item       (in_item),
    .cfg        (cfg),
    .state_next (state_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.menu_count       <= MENU_COUNT_RESET;
      cfg.detent_threshold <= DETENT_THRESHOLD_RESET;
      cfg.level_threshold  <= LEVEL_THRESHOLD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MENU_COUNT:       cfg.menu_count       <= cfg_data[2:0];
        REG_DETENT_THRESHOLD: cfg.detent_threshold <= cfg_data[5:0];
        REG_LEVEL_THRESHOLD:  cfg.level_threshold  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (load_in) begin
      in_vld <= 1'b1;
    end else if (fire) begin
      in_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_in) begin
      in_item.kind       <= s_axis_tuser;
      in_item.pin_a      <= s_axis_tdata[0];
      in_item.pin_b      <= s_axis_tdata[1];
      in_item.level_low  <= s_axis_tdata[11:2];
      in_item.level_mid  <= s_axis_tdata[21:12];
      in_item.level_high <= s_axis_tdata[31:22];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.mode        <= MODE_VIEW;
      state.prev_a      <= 1'b0;
      state.prev_b      <= 1'b0;
      state.detent      <= 7'sd0;
      state.menu_pos    <= 2'd0;
      state.ph          <= PH_RESET;
      state.nutrient    <= NUT_RESET;
      state.water_goal  <= WATER_RESET;
      state.water_level <= 2'd0;
      state.pump        <= 1'b0;
    end else if (fire) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (fire) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_axis_tdata <= {2'b00, state_next.pump, state_next.water_level,
                       state_next.water_goal, state_next.nutrient, state_next.ph,
                       state_next.menu_pos, state_next.mode};
    end
  end

endmodule

`default_nettype wire

>>> tb/sv/tb_rotary_encoder_settings_menu.sv
// ----------------------------------------------------------------------------
// Rotary encoder settings menu testbench
// Drives encoder pin samples, button presses and water sensor samples into
// the menu block, predicts every result from a behavioral copy of the menu
// state, and checks each output transfer field by field. A short directed
// table runs first, then randomized knob turns, presses and sensor samples
// over several register settings, with bursty input and a stalling output.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_rotary_encoder_settings_menu;
  import rem_pkg::*;

  typedef struct packed {
    logic       pump;
    logic [1:0] water_now;
    logic [1:0] water_goal;
    logic [4:0] nutrient;
    logic [6:0] ph;
    logic [1:0] entry;
    logic [2:0] mode;
  } view_t;

  typedef struct {
    logic [1:0]  kind;
    logic [31:0] data;
    bit          fixed;
    view_t       view;
  } dir_row_t;

  localparam int ITEMS_PER_PHASE = 235;
  localparam int NUM_PHASES      = 8;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [9:0]  cfg_data = '0;

  rotary_encoder_settings_menu u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Behavioral copy of the menu state and its registers.
  logic [2:0] set_menu_count = MENU_COUNT_RESET;
  logic [5:0] set_detent     = DETENT_THRESHOLD_RESET;
  logic [9:0] set_wet_level  = LEVEL_THRESHOLD_RESET;

  mode_t ui_mode    = MODE_VIEW;
  logic  last_a     = 1'b0;
  logic  last_b     = 1'b0;
  int    detent     = 0;
  int    menu_idx   = 0;
  int    ph_set     = 65;
  int    nut_set    = 2;
  int    goal_set   = 3;
  int    wet_count  = 0;
  logic  pump_run   = 1'b0;

  view_t expected_views[$];
  int    err_count  = 0;
  int    burst_left = 1;
  int    run_left   = 0;
  bit    run_cw     = 1'b1;

  function automatic view_t mk_view(mode_t m, int entry, int ph, int nut, int goal,
                                    int wet, logic pump);
    view_t v;
    v.mode       = m;
    v.entry      = entry[1:0];
    v.ph         = ph[6:0];
    v.nutrient   = nut[4:0];
    v.water_goal = goal[1:0];
    v.water_now  = wet[1:0];
    v.pump       = pump;
    return v;
  endfunction

  function automatic logic [31:0] enc_data(logic a, logic b, logic [9:0] lo,
                                           logic [9:0] mid, logic [9:0] hi);
    return {hi, mid, lo, b, a};
  endfunction

  function automatic void turn_knob(bit cw);
    int cnt;
    int th;
    cnt = (set_menu_count < 1) ? 1 : (set_menu_count > 4) ? 4 : int'(set_menu_count);
    th  = (set_detent > 62) ? 62 : int'(set_detent);
    case (ui_mode)
      MODE_MENU: begin
        if (cw) begin
          detent++;
          if (detent > th) begin
            menu_idx++;
            detent = 0;
          end
          if (menu_idx >= cnt) menu_idx = 0;
        end else begin
          detent--;
          if (detent < -th) begin
            menu_idx--;
            detent = 0;
          end
          if (menu_idx < 0) menu_idx = cnt - 1;
        end
      end
      MODE_EDIT_PH: begin
        ph_set = cw ? ph_set + 1 : ph_set - 1;
        if (ph_set > 100) ph_set = 100;
        if (ph_set < 30) ph_set = 30;
      end
      MODE_EDIT_NUT: begin
        nut_set = cw ? nut_set + 1 : nut_set - 1;
        if (nut_set > 20) nut_set = 20;
        if (nut_set < 0) nut_set = 0;
      end
      MODE_EDIT_WATER: begin
        goal_set = cw ? goal_set + 1 : goal_set - 1;
        if (goal_set > 3) goal_set = 3;
        if (goal_set < 1) goal_set = 1;
      end
      default: begin
      end
    endcase
  endfunction

  function automatic view_t predict_view(logic [1:0] kind, logic [31:0] data);
    logic a;
    logic b;
    a = data[0];
    b = data[1];
    case (kind)
      KIND_ENC: begin
        if (a != last_a) turn_knob(a != b);
        else if (b != last_b) turn_knob(a == b);
        last_a = a;
        last_b = b;
      end
      KIND_BTN: begin
        case (ui_mode)
          MODE_VIEW: ui_mode = MODE_MENU;
          MODE_MENU: begin
            case (menu_idx & 3)
              0: ui_mode = MODE_EDIT_PH;
              1: ui_mode = MODE_EDIT_NUT;
              2: ui_mode = MODE_EDIT_WATER;
              default: ui_mode = MODE_VIEW;
            endcase
          end
          MODE_EDIT_PH, MODE_EDIT_NUT, MODE_EDIT_WATER: begin
            ui_mode  = MODE_MENU;
            pump_run = (wet_count < goal_set);
          end
          default: begin
          end
        endcase
      end
      KIND_WATER: begin
        wet_count = (data[11:2] > set_wet_level) + (data[21:12] > set_wet_level)
                  + (data[31:22] > set_wet_level);
        pump_run  = (wet_count < goal_set);
      end
      default: begin
      end
    endcase
    return mk_view(ui_mode, menu_idx, ph_set, nut_set, goal_set, wet_count, pump_run);
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_count++;
    end
  endtask

  always @(posedge clk) begin : result_check
    view_t want;
    view_t got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[21:0];
      if (expected_views.size() == 0) begin
        $error("result transfer with no expectation pending: %h", m_axis_tdata);
        err_count++;
      end else begin
        want = expected_views.pop_front();
        check_field("mode", want.mode, got.mode);
        check_field("selected_entry", want.entry, got.entry);
        check_field("ph_target_tenths", want.ph, got.ph);
        check_field("nutrient_setting", want.nutrient, got.nutrient);
        check_field("water_target", want.water_goal, got.water_goal);
        check_field("water_now", want.water_now, got.water_now);
        check_field("pump_on", want.pump, got.pump);
        check_field("zero_fill", 0, m_axis_tdata[23:22]);
      end
    end
  end

  logic [10:0] stall_cycle = '0;

  always @(posedge clk) begin
    stall_cycle <= stall_cycle + 1'b1;
    case (stall_cycle[10:8])
      3'd0, 3'd1: m_axis_tready <= 1'b1;
      3'd2:       m_axis_tready <= stall_cycle[0];
      3'd3:       m_axis_tready <= ($urandom_range(0, 3) != 0);
      3'd4:       m_axis_tready <= (stall_cycle[3:0] < 4'd3);
      3'd5:       m_axis_tready <= $urandom_range(0, 1);
      default:    m_axis_tready <= ($urandom_range(0, 9) != 0);
    endcase
  end

  task automatic send_item(input logic [1:0] kind, input logic [31:0] data,
                           output view_t pred);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= data;
    do @(posedge clk); while (!s_axis_tready);
    pred = predict_view(kind, data);
  endtask

  task automatic pause_sender(input int cycles);
    s_axis_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic pace_sender();
    burst_left--;
    if (burst_left <= 0) begin
      pause_sender($urandom_range(1, 6));
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
    end
  endtask

  task automatic wait_drained();
    while (expected_views.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [9:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_MENU_COUNT:       set_menu_count = val[2:0];
      REG_DETENT_THRESHOLD: set_detent     = val[5:0];
      REG_LEVEL_THRESHOLD:  set_wet_level  = val;
      default: begin
      end
    endcase
  endtask

  task automatic write_settings(input int count, input int thresh, input int wet);
    write_reg(REG_MENU_COUNT, count[9:0]);
    write_reg(REG_DETENT_THRESHOLD, thresh[9:0]);
    write_reg(REG_LEVEL_THRESHOLD, wet[9:0]);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [9:0] pick_level();
    int lvl;
    case ($urandom_range(0, 5))
      0: lvl = int'(set_wet_level) - 1;
      1: lvl = set_wet_level;
      2: lvl = int'(set_wet_level) + 1;
      3: lvl = $urandom_range(0, 1) ? 1023 : 0;
      default: lvl = $urandom_range(0, 1023);
    endcase
    if (lvl < 0) lvl = 0;
    if (lvl > 1023) lvl = 1023;
    return lvl[9:0];
  endfunction

  // Next pin pair one quadrature step away from the last sampled pins.
  function automatic logic [1:0] gray_step(bit cw);
    int pos;
    pos = last_b ? (last_a ? 2 : 3) : (last_a ? 1 : 0);
    pos = cw ? (pos + 1) % 4 : (pos + 3) % 4;
    return {pos >= 2, pos == 1 || pos == 2};
  endfunction

  task automatic next_item(output logic [1:0] kind, output logic [31:0] data);
    logic [1:0] pins;
    int pick;
    data = $urandom();
    kind = KIND_ENC;
    if (run_left == 0) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        run_cw   = $urandom_range(0, 1);
        run_left = (pick < 5) ? $urandom_range(30, 70) : $urandom_range(1, 16);
      end else if (pick < 65) begin
        kind = KIND_BTN;
      end else if (pick < 80) begin
        kind = KIND_WATER;
        data[11:2]  = pick_level();
        data[21:12] = pick_level();
        data[31:22] = pick_level();
      end else if (pick >= 92) begin
        kind = KIND_UNUSED;
      end
    end
    if (run_left > 0) begin
      pins     = gray_step(run_cw);
      data[0]  = pins[0];
      data[1]  = pins[1];
      run_left--;
    end
  endtask

  initial begin : stimulus
    dir_row_t   rows[$];
    view_t      v0;
    view_t      pred;
    logic [1:0] kind;
    logic [31:0] data;
    int count;
    int thresh;
    int wet;

    v0 = mk_view(MODE_VIEW, 0, 65, 2, 3, 0, 1'b0);
    rows.push_back('{KIND_UNUSED, 32'h0, 1'b1, v0});
    rows.push_back('{KIND_UNUSED, 32'hffff_ffff, 1'b1, v0});
    rows.push_back('{KIND_ENC, enc_data(1, 0, 10'h3ff, 10'h3ff, 10'h3ff), 1'b1, v0});
    rows.push_back('{KIND_ENC, enc_data(1, 1, 0, 0, 0), 1'b1, v0});
    rows.push_back('{KIND_WATER, enc_data(1, 1, 10'h3ff, 10'h3ff, 10'h3ff), 1'b1,
                     mk_view(MODE_VIEW, 0, 65, 2, 3, 3, 1'b0)});
    rows.push_back('{KIND_WATER, enc_data(0, 0, 0, 0, 0), 1'b1,
                     mk_view(MODE_VIEW, 0, 65, 2, 3, 0, 1'b1)});
    rows.push_back('{KIND_WATER, enc_data(0, 0, 100, 101, 100), 1'b0, v0});
    rows.push_back('{KIND_WATER, enc_data(1, 0, 101, 10'h3ff, 0), 1'b0, v0});
    rows.push_back('{KIND_BTN, 32'hffff_ffff, 1'b0, v0});
    rows.push_back('{KIND_ENC, enc_data(0, 1, 0, 0, 0), 1'b0, v0});
    rows.push_back('{KIND_ENC, enc_data(0, 0, 0, 0, 0), 1'b0, v0});
    rows.push_back('{KIND_ENC, enc_data(0, 1, 0, 0, 0), 1'b0, v0});
    rows.push_back('{KIND_BTN, 32'h0, 1'b0, v0});
    rows.push_back('{KIND_ENC, enc_data(1, 1, 10'h155, 10'h2aa, 10'h155), 1'b0, v0});
    rows.push_back('{KIND_ENC, enc_data(0, 0, 0, 0, 0), 1'b0, v0});
    rows.push_back('{KIND_ENC, enc_data(0, 0, 0, 0, 0), 1'b0, v0});
    rows.push_back('{KIND_ENC, enc_data(1, 0, 0, 0, 0), 1'b0, v0});
    rows.push_back('{KIND_BTN, 32'h0, 1'b0, v0});
    rows.push_back('{KIND_UNUSED, 32'h5a5a_a5a5, 1'b0, v0});
    rows.push_back('{KIND_WATER, enc_data(0, 1, 10'h3ff, 0, 10'h3ff), 1'b0, v0});

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) begin
      send_item(rows[i].kind, rows[i].data, pred);
      expected_views.push_back(rows[i].fixed ? rows[i].view : pred);
      pace_sender();
    end

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      pause_sender(1);
      wait_drained();
      case (phase)
        0: begin count = 4; thresh = 10; wet = 100;  end
        1: begin count = 1; thresh = 1;  wet = 0;    end
        2: begin count = 0; thresh = 0;  wet = 1023; end
        3: begin count = 7; thresh = 63; wet = 512;  end
        4: begin count = 2; thresh = 62; wet = 1;    end
        5: begin count = 3; thresh = 2;  wet = 1022; end
        6: begin count = 5; thresh = 5;  wet = $urandom_range(0, 1023); end
        default: begin
          count  = $urandom_range(0, 7);
          thresh = $urandom_range(0, 63);
          wet    = $urandom_range(0, 1023);
        end
      endcase
      write_settings(count, thresh, wet);
      run_left = 0;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        next_item(kind, data);
        send_item(kind, data, pred);
        expected_views.push_back(pred);
        pace_sender();
      end
    end

    pause_sender(1);
    wait_drained();
    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire
